// ===== hw/rtl/ste_pkg.sv =====
// ----------------------------------------------------------------------------
// ste_pkg
// types, action codes and controller commands for the sorted table engine
// ----------------------------------------------------------------------------
package ste_pkg;

    localparam logic [2:0] ACT_INSERT  = 3'd0;
    localparam logic [2:0] ACT_PREPEND = 3'd1;
    localparam logic [2:0] ACT_APPEND  = 3'd2;
    localparam logic [2:0] ACT_REMOVE  = 3'd3;
    localparam logic [2:0] ACT_READ    = 3'd4;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH,
        S_SRCH_CHK,
        S_SHIFT,
        S_SHIFT_WR,
        S_RM,
        S_RM_WR,
        S_RD_WAIT,
        S_CHK,
        S_CHK_CMP,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_COUNT,
        PTR_INDEX_INC,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        POS_HOLD,
        POS_ZERO,
        POS_COUNT,
        POS_PTR
    } t_pos_op;

    typedef enum logic [1:0] {
        RA_PTR,
        RA_PTR_M1,
        RA_INDEX
    } t_rd_sel;

    typedef enum logic [1:0] {
        WA_PTR,
        WA_PTR_M1,
        WA_POS
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        t_ptr_op ptr_op;
        t_pos_op pos_op;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    ok_init;
        logic    ok_upd;
        logic    rdv_load;
        logic    st_wr;
        t_status st_val;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] act;
        logic       full;
        logic       range;
        logic       ptr_eq_cnt;
        logic       ptr_eq_pos;
        logic       gt;
        logic       out_free;
    } t_stat;

endpackage

// ===== hw/rtl/ste_ram.sv =====
// ----------------------------------------------------------------------------
// ste_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ste_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ste_dpath.sv =====
// ----------------------------------------------------------------------------
// ste_dpath
// entry memory, fill count, pointers, order flag and result register
// ----------------------------------------------------------------------------
module ste_dpath
    import ste_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [2:0]          i_action,
    input  logic signed [31:0]  i_value,
    input  logic [7:0]          i_index,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic signed [31:0]  o_read_value,
    output logic [8:0]          o_fill_count,
    output logic                o_in_order,
    output t_status             o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [2:0]         r_act;
    logic signed [31:0] r_value;
    logic [7:0]         r_index;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_ptr, n_ptr;
    logic [CW-1:0]      r_pos, n_pos;
    logic signed [31:0] r_prev;
    logic               r_ok, n_ok;
    logic signed [31:0] r_rdv, n_rdv;
    t_status            r_st, n_st;
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_out_rdv;
    logic [CW-1:0]      r_out_cnt;
    logic               r_out_ok;
    t_status            r_out_st;

    logic [CW+7:0]      w_idx_ext;
    logic [CW+7:0]      w_cnt_ext;
    logic [AW+7:0]      w_idx_addr;
    logic [CW+8:0]      w_out_cnt_ext;
    logic [CW-1:0]      w_ptr_m1;
    logic [AW-1:0]      w_raddr;
    logic [AW-1:0]      w_waddr;
    logic [31:0]        w_wdata;
    logic signed [31:0] w_rdata;
    logic               w_le;

    assign w_idx_ext  = {{CW{1'b0}}, r_index};
    assign w_cnt_ext  = {8'b0, r_count};
    assign w_idx_addr = {{AW{1'b0}}, r_index};
    assign w_ptr_m1   = r_ptr - 1'b1;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RA_PTR:    w_raddr = r_ptr[AW-1:0];
            RA_PTR_M1: w_raddr = w_ptr_m1[AW-1:0];
            RA_INDEX:  w_raddr = w_idx_addr[AW-1:0];
            default:   w_raddr = r_ptr[AW-1:0];
        endcase
        unique case (i_cmd.wr_sel)
            WA_PTR: begin
                w_waddr = r_ptr[AW-1:0];
                w_wdata = w_rdata;
            end
            WA_PTR_M1: begin
                w_waddr = w_ptr_m1[AW-1:0];
                w_wdata = w_rdata;
            end
            WA_POS: begin
                w_waddr = r_pos[AW-1:0];
                w_wdata = r_value;
            end
            default: begin
                w_waddr = r_pos[AW-1:0];
                w_wdata = r_value;
            end
        endcase
    end

    ste_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_le = (w_rdata <= r_prev);

    assign o_stat.act        = r_act;
    assign o_stat.full       = (r_count == FULL_CNT);
    assign o_stat.range      = (w_idx_ext >= w_cnt_ext);
    assign o_stat.ptr_eq_cnt = (r_ptr == r_count);
    assign o_stat.ptr_eq_pos = (r_ptr == r_pos);
    assign o_stat.gt         = (r_value > w_rdata);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (i_cmd.ptr_op)
            PTR_HOLD:      n_ptr = r_ptr;
            PTR_ZERO:      n_ptr = '0;
            PTR_COUNT:     n_ptr = r_count;
            PTR_INDEX_INC: n_ptr = w_idx_ext[CW-1:0] + 1'b1;
            PTR_INC:       n_ptr = r_ptr + 1'b1;
            PTR_DEC:       n_ptr = w_ptr_m1;
            default:       n_ptr = r_ptr;
        endcase
        unique case (i_cmd.pos_op)
            POS_HOLD:  n_pos = r_pos;
            POS_ZERO:  n_pos = '0;
            POS_COUNT: n_pos = r_count;
            POS_PTR:   n_pos = r_ptr;
            default:   n_pos = r_pos;
        endcase

        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - 1'b1;
        end

        n_ok = r_ok;
        if (i_cmd.ok_init) begin
            n_ok = 1'b1;
        end else if (i_cmd.ok_upd && (r_ptr != '0) && w_le) begin
            n_ok = 1'b0;
        end

        n_rdv = r_rdv;
        n_st  = r_st;
        if (i_cmd.load) begin
            n_rdv = '0;
            n_st  = ST_DONE;
        end else begin
            if (i_cmd.rdv_load) begin
                n_rdv = w_rdata;
            end
            if (i_cmd.st_wr) begin
                n_st = i_cmd.st_val;
            end
        end

        n_out_valid = r_out_valid;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ok        <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_ok        <= n_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_pos <= n_pos;
        r_rdv <= n_rdv;
        r_st  <= n_st;
        if (i_cmd.load) begin
            r_act   <= i_action;
            r_value <= i_value;
            r_index <= i_index;
        end
        if (i_cmd.ok_upd) begin
            r_prev <= w_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_rdv <= r_rdv;
            r_out_cnt <= r_count;
            r_out_ok  <= r_ok;
            r_out_st  <= r_st;
        end
    end

    assign w_out_cnt_ext = {9'b0, r_out_cnt};
    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_rdv;
    assign o_fill_count  = w_out_cnt_ext[8:0];
    assign o_in_order    = r_out_ok;
    assign o_status      = r_out_st;

`ifndef NO_ASSERTIONS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill count above depth");

    a_no_insert_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> (r_count != FULL_CNT))
        else $error("entry placed into full table");

    a_no_remove_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> (r_count != '0) && !i_cmd.cnt_inc)
        else $error("remove from empty table");

    a_read_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_en && (i_cmd.rd_sel == RA_INDEX)) |-> (w_idx_ext < w_cnt_ext))
        else $error("indexed read beyond fill count");
`endif

endmodule

// ===== hw/rtl/ste_ctrl.sv =====
// ----------------------------------------------------------------------------
// ste_ctrl
// sequencer for search, shift, remove, read and order scan
// ----------------------------------------------------------------------------
module ste_ctrl
    import ste_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.ptr_op   = PTR_HOLD;
        o_cmd.pos_op   = POS_HOLD;
        o_cmd.rd_sel   = RA_PTR;
        o_cmd.wr_sel   = WA_POS;
        o_cmd.st_val   = ST_DONE;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.act) inside
                    ACT_INSERT, ACT_PREPEND, ACT_APPEND: begin
                        if (i_stat.full) begin
                            o_cmd.st_wr  = 1'b1;
                            o_cmd.st_val = ST_FULL;
                            n_state      = S_DONE;
                        end else if (i_stat.act == ACT_INSERT) begin
                            o_cmd.ptr_op = PTR_ZERO;
                            n_state      = S_SRCH;
                        end else begin
                            o_cmd.ptr_op = PTR_COUNT;
                            o_cmd.pos_op = (i_stat.act == ACT_PREPEND) ? POS_ZERO : POS_COUNT;
                            n_state      = S_SHIFT;
                        end
                    end
                    ACT_REMOVE, ACT_READ: begin
                        if (i_stat.range) begin
                            o_cmd.st_wr  = 1'b1;
                            o_cmd.st_val = ST_RANGE;
                            n_state      = S_DONE;
                        end else if (i_stat.act == ACT_READ) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RA_INDEX;
                            n_state      = S_RD_WAIT;
                        end else begin
                            o_cmd.ptr_op = PTR_INDEX_INC;
                            n_state      = S_RM;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SRCH: begin
                if (i_stat.ptr_eq_cnt) begin
                    o_cmd.pos_op = POS_PTR;
                    o_cmd.ptr_op = PTR_COUNT;
                    n_state      = S_SHIFT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_PTR;
                    n_state      = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK: begin
                if (i_stat.gt) begin
                    o_cmd.ptr_op = PTR_INC;
                    n_state      = S_SRCH;
                end else begin
                    o_cmd.pos_op = POS_PTR;
                    o_cmd.ptr_op = PTR_COUNT;
                    n_state      = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_stat.ptr_eq_pos) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = WA_POS;
                    o_cmd.cnt_inc = 1'b1;
                    o_cmd.ptr_op  = PTR_ZERO;
                    o_cmd.ok_init = 1'b1;
                    n_state       = S_CHK;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_PTR_M1;
                    n_state      = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WA_PTR;
                o_cmd.ptr_op = PTR_DEC;
                n_state      = S_SHIFT;
            end
            S_RM: begin
                if (i_stat.ptr_eq_cnt) begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.ptr_op  = PTR_ZERO;
                    o_cmd.ok_init = 1'b1;
                    n_state       = S_CHK;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_PTR;
                    n_state      = S_RM_WR;
                end
            end
            S_RM_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WA_PTR_M1;
                o_cmd.ptr_op = PTR_INC;
                n_state      = S_RM;
            end
            S_RD_WAIT: begin
                o_cmd.rdv_load = 1'b1;
                n_state        = S_DONE;
            end
            S_CHK: begin
                if (i_stat.ptr_eq_cnt) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_PTR;
                    n_state      = S_CHK_CMP;
                end
            end
            S_CHK_CMP: begin
                o_cmd.ok_upd = 1'b1;
                o_cmd.ptr_op = PTR_INC;
                n_state      = S_CHK;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/sorted_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// sorted_table_engine_core
// table of signed 32-bit values with sorted insert, prepend, append,
// remove and indexed read
// ----------------------------------------------------------------------------
// One transaction is worked at a time. The next one is taken only after the
// previous result has moved into the output register, and a finished result
// waits in the engine while the receiver still holds the one before it. The
// entries live in one RAM with a single write and a single registered read
// port, and each entry that is searched, moved or checked takes a read state
// and a compare or write state on that port. A read fetches the indexed entry;
// an action dropped for a full table or bad index, or an unused action code,
// goes straight to the result. Sorted insert finds the first entry not below
// the value from the front and shifts the rest up; prepend shifts all entries
// up, append none, and remove moves those after the index down by one.
// Modifying actions end with a scan of the whole table that refreshes the
// in-order flag. No clearing pass follows reset; the table is empty at once.
module sorted_table_engine_core
    import ste_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], index[39:32]
    input  logic [2:0]  s_axis_tuser,   // action[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // read_value[31:0], fill_count[40:32],
                                        // in_order[41], zero[47:42]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    t_cmd               w_cmd;
    t_stat              w_stat;
    logic signed [31:0] w_read_value;
    logic [8:0]         w_fill_count;
    logic               w_in_order;
    t_status            w_status;

    ste_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ste_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_action     (s_axis_tuser),
        .i_value      (s_axis_tdata[31:0]),
        .i_index      (s_axis_tdata[39:32]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_read_value (w_read_value),
        .o_fill_count (w_fill_count),
        .o_in_order   (w_in_order),
        .o_status     (w_status)
    );

    assign m_axis_tdata = {6'b0, w_in_order, w_fill_count, w_read_value};
    assign m_axis_tuser = w_status;

endmodule

// ===== bench/sorted_table_engine_core_test.sv =====
// ----------------------------------------------------------------------------
// sorted_table_engine_core_test
// self-checking bench for the sorted table engine core: a short table of
// directed transactions, then random traffic that runs the table small,
// fills it to the top, holds it full and drains it, each result checked
// against a cycle-free model or a typed row under several idle patterns
// ----------------------------------------------------------------------------
module sorted_table_engine_core_test
    import ste_pkg::*;
();

    localparam int TABLE_DEPTH  = 256;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int DRAIN_CYCLES = 1100;
    localparam int SMALL_ITEMS  = 150;
    localparam int FULL_ITEMS   = 24;
    localparam int MAX_PRINTS   = 100;

    localparam logic [2:0] ACT_SPARE_0 = 3'd5;
    localparam logic [2:0] ACT_SPARE_1 = 3'd6;
    localparam logic [2:0] ACT_SPARE_2 = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh80000000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFFFFFF;

    typedef struct packed {
        logic signed [31:0] rd_value;
        logic [8:0]         count;
        logic               ordered;
        t_status            status;
    } t_table_resp;

    typedef struct packed {
        logic [2:0]         act;
        logic signed [31:0] value;
        logic [7:0]         index;
        logic               typed;
        t_table_resp        resp;
    } t_table_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // value[31:0], index[39:32]
    logic [2:0]  s_axis_tuser;   // action[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // read_value[31:0], fill_count[40:32], in_order[41]
    logic [1:0]  m_axis_tuser;   // status[1:0]

    logic signed [31:0] model_tbl [TABLE_DEPTH];
    int                 model_cnt;
    t_table_resp        resp_q [$];
    t_table_row         dir_rows [$];
    int                 snd_idle_pct;
    int                 rcv_stall_pct;
    int                 errors;
    int                 results_seen;
    int                 cycles;

    sorted_table_engine_core #(
        .DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // table model: applies one action, returns the response it produces
    function automatic t_table_resp apply_table_action(input logic [2:0] act,
                                                       input logic signed [31:0] v,
                                                       input logic [7:0] idx);
        t_table_resp r;
        int          pos;
        r = '0;
        r.status = ST_DONE;
        case (act)
            ACT_INSERT, ACT_PREPEND, ACT_APPEND: begin
                if (model_cnt >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (act == ACT_PREPEND) begin
                        pos = 0;
                    end else if (act == ACT_APPEND) begin
                        pos = model_cnt;
                    end else begin
                        pos = 0;
                        while (pos < model_cnt && v > model_tbl[pos])
                            pos++;
                    end
                    for (int i = model_cnt; i > pos; i--)
                        model_tbl[i] = model_tbl[i - 1];
                    model_tbl[pos] = v;
                    model_cnt++;
                end
            end
            ACT_REMOVE, ACT_READ: begin
                if (int'(idx) >= model_cnt) begin
                    r.status = ST_RANGE;
                end else if (act == ACT_READ) begin
                    r.rd_value = model_tbl[idx];
                end else begin
                    for (int i = idx; i + 1 < model_cnt; i++)
                        model_tbl[i] = model_tbl[i + 1];
                    model_cnt--;
                end
            end
            default: begin
            end
        endcase
        r.count = model_cnt[8:0];
        r.ordered = 1'b1;
        for (int i = 1; i < model_cnt; i++)
            if (!(model_tbl[i] > model_tbl[i - 1]))
                r.ordered = 1'b0;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $signed($urandom_range(0, 16)) - 8;
        if (r < 45) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("result %0d: %s got %h want %h", results_seen, what, got, want);
    endtask

    task automatic add_row(input t_table_row row);
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic set_idle_mode(input int n);
        case ((n / 64) % 4)
            0: begin
                snd_idle_pct = 0;
                rcv_stall_pct = 0;
            end
            1: begin
                snd_idle_pct = 59;
                rcv_stall_pct = 0;
            end
            2: begin
                snd_idle_pct = 0;
                rcv_stall_pct = 59;
            end
            default: begin
                snd_idle_pct = 21;
                rcv_stall_pct = 21;
            end
        endcase
    endtask

    // drives one transaction, waits for it to be taken, records the response
    task automatic send_action(input logic [2:0] act, input logic signed [31:0] v,
                               input logic [7:0] idx, input logic typed,
                               input t_table_resp typed_resp);
        t_table_resp want;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {idx, v};
        s_axis_tuser <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        want = apply_table_action(act, v, idx);
        resp_q.insert(resp_q.size(), typed ? typed_resp : want);
    endtask

    // mostly well-formed traffic on a table kept to a couple dozen entries
    task automatic pick_small_action(output logic [2:0] act, output logic signed [31:0] v,
                                     output logic [7:0] idx);
        int r;
        logic crowded;
        r = $urandom_range(0, 99);
        crowded = (model_cnt > 20);
        v = pick_value();
        if (model_cnt > 0 && $urandom_range(0, 99) < 85)
            idx = 8'($urandom_range(0, model_cnt - 1));
        else
            idx = 8'($urandom_range(0, 255));
        if (r < 30 && !crowded)
            act = ACT_INSERT;
        else if (r < 40 && !crowded)
            act = ACT_PREPEND;
        else if (r < 50 && !crowded)
            act = ACT_APPEND;
        else if (r < 72)
            act = ACT_REMOVE;
        else if (r < 95)
            act = ACT_READ;
        else
            act = 3'($urandom_range(ACT_SPARE_0, ACT_SPARE_2));
    endtask

    always @(posedge i_clk) begin
        t_table_resp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (resp_q.size() == 0) begin
                flag_error("unexpected result", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = resp_q.pop_front();
                if (m_axis_tdata[31:0] !== want.rd_value)
                    flag_error("read_value", m_axis_tdata[31:0], want.rd_value);
                if (m_axis_tdata[40:32] !== want.count)
                    flag_error("fill_count", m_axis_tdata[40:32], want.count);
                if (m_axis_tdata[41] !== want.ordered)
                    flag_error("in_order", m_axis_tdata[41], want.ordered);
                if (m_axis_tdata[47:42] !== 6'd0)
                    flag_error("padding", m_axis_tdata[47:42], 32'd0);
                if (m_axis_tuser !== want.status)
                    flag_error("status", m_axis_tuser, want.status);
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [2:0]         act;
        logic signed [31:0] v;
        logic [7:0]         idx;
        logic signed [31:0] ramp;
        int                 r;
        int                 n_rand;
        int                 k;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        m_axis_tready <= 1'b0;
        i_rst_n <= 1'b0;
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        errors = 0;
        results_seen = 0;
        model_cnt = 0;
        n_rand = 0;

        // empty table, extremes, equal values, both ends, bad indexes, spare codes
        add_row('{ACT_READ, 32'sd0, 8'd0, 1'b1, '{32'sd0, 9'd0, 1'b1, ST_RANGE}});
        add_row('{ACT_REMOVE, 32'sd0, 8'd0, 1'b1, '{32'sd0, 9'd0, 1'b1, ST_RANGE}});
        add_row('{ACT_SPARE_0, -32'sd1, 8'hFF, 1'b1,
                  '{32'sd0, 9'd0, 1'b1, ST_DONE}});
        add_row('{ACT_INSERT, 32'sd0, 8'd0, 1'b1, '{32'sd0, 9'd1, 1'b1, ST_DONE}});
        add_row('{ACT_INSERT, VAL_MAX, 8'd0, 1'b1, '{32'sd0, 9'd2, 1'b1, ST_DONE}});
        add_row('{ACT_INSERT, VAL_MIN, 8'd0, 1'b1, '{32'sd0, 9'd3, 1'b1, ST_DONE}});
        add_row('{ACT_INSERT, 32'sd0, 8'd0, 1'b1, '{32'sd0, 9'd4, 1'b0, ST_DONE}});
        add_row('{ACT_READ, 32'sd0, 8'd1, 1'b0, '0});
        add_row('{ACT_PREPEND, 32'sd5, 8'd0, 1'b0, '0});
        add_row('{ACT_APPEND, -32'sd1, 8'd0, 1'b0, '0});
        add_row('{ACT_READ, 32'sd0, 8'd0, 1'b0, '0});
        add_row('{ACT_READ, 32'sd0, 8'd5, 1'b0, '0});
        add_row('{ACT_READ, 32'sd0, 8'd6, 1'b1, '{32'sd0, 9'd6, 1'b0, ST_RANGE}});
        add_row('{ACT_REMOVE, 32'sd0, 8'd0, 1'b0, '0});
        add_row('{ACT_REMOVE, 32'sd0, 8'd4, 1'b0, '0});
        add_row('{ACT_REMOVE, 32'sd0, 8'd255, 1'b1,
                  '{32'sd0, 9'd4, 1'b0, ST_RANGE}});
        add_row('{ACT_SPARE_2, 32'sd0, 8'd0, 1'b1, '{32'sd0, 9'd4, 1'b0, ST_DONE}});
        add_row('{ACT_SPARE_1, 32'sh5A5A5A5A, 8'hA5, 1'b0, '0});
        add_row('{ACT_REMOVE, 32'sd0, 8'd1, 1'b0, '0});
        add_row('{ACT_READ, 32'sd0, 8'd2, 1'b0, '0});
        add_row('{ACT_REMOVE, 32'sd0, 8'd0, 1'b0, '0});
        add_row('{ACT_REMOVE, 32'sd0, 8'd0, 1'b0, '0});
        add_row('{ACT_REMOVE, 32'sd0, 8'd0, 1'b0, '0});
        add_row('{ACT_READ, 32'sd0, 8'd0, 1'b1, '{32'sd0, 9'd0, 1'b1, ST_RANGE}});
        add_row('{ACT_PREPEND, 32'shAAAAAAAA, 8'hAA, 1'b0, '0});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[j])
            send_action(dir_rows[j].act, dir_rows[j].value, dir_rows[j].index,
                        dir_rows[j].typed, dir_rows[j].resp);

        for (k = 0; k < SMALL_ITEMS; k++) begin
            set_idle_mode(n_rand++);
            pick_small_action(act, v, idx);
            send_action(act, v, idx, 1'b0, '0);
        end

        // hold off until the block has answered everything
        s_axis_tvalid <= 1'b0;
        while (resp_q.size() != 0)
            @(posedge i_clk);

        // fill to the top, mostly with an ascending ramp
        ramp = VAL_MIN + $signed($urandom_range(0, 1 << 20));
        while (model_cnt < TABLE_DEPTH) begin
            set_idle_mode(n_rand++);
            r = $urandom_range(0, 99);
            if (r < 80) begin
                ramp = ramp + $signed($urandom_range(1, 1 << 20));
                send_action(ACT_APPEND, ramp, 8'($urandom_range(0, 255)), 1'b0, '0);
            end else if (r < 90) begin
                send_action(ACT_INSERT, pick_value(), 8'($urandom_range(0, 255)), 1'b0, '0);
            end else begin
                send_action(ACT_PREPEND, pick_value(), 8'($urandom_range(0, 255)), 1'b0,
                            '0);
            end
        end

        // full table: every write kind dropped, reads across the whole range
        for (k = 0; k < FULL_ITEMS; k++) begin
            set_idle_mode(n_rand++);
            if (k % 2 == 0) begin
                case ((k / 2) % 3)
                    0: act = ACT_INSERT;
                    1: act = ACT_PREPEND;
                    default: act = ACT_APPEND;
                endcase
                send_action(act, pick_value(), 8'($urandom_range(0, 255)), 1'b0, '0);
            end else begin
                idx = (k == 1) ? 8'd255 : 8'($urandom_range(0, 255));
                send_action(ACT_READ, pick_value(), idx, 1'b0, '0);
            end
        end

        // drain, mostly from the back end to keep the shifts short
        while (model_cnt > 8) begin
            set_idle_mode(n_rand++);
            r = $urandom_range(0, 99);
            if (r < 55) begin
                idx = 8'(model_cnt - 1 - $urandom_range(0, 3));
                send_action(ACT_REMOVE, pick_value(), idx, 1'b0, '0);
            end else if (r < 70) begin
                idx = 8'($urandom_range(0, model_cnt - 1));
                send_action(ACT_REMOVE, pick_value(), idx, 1'b0, '0);
            end else begin
                idx = 8'($urandom_range(0, model_cnt - 1));
                send_action(ACT_READ, pick_value(), idx, 1'b0, '0);
            end
        end

        for (k = 0; k < SMALL_ITEMS; k++) begin
            set_idle_mode(n_rand++);
            pick_small_action(act, v, idx);
            send_action(act, v, idx, 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (resp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (resp_q.size() != 0)
            flag_error("missing result", resp_q.size(), 32'd0);

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ste_pkg.sv
hw/rtl/ste_ram.sv
hw/rtl/ste_dpath.sv
hw/rtl/ste_ctrl.sv
hw/rtl/sorted_table_engine_core.sv
bench/sorted_table_engine_core_test.sv
